// File: rtl/core/tcv_pkg.sv
// Shared types and constants of the Type III voltage-loop compensator.
// Used by the register file, the controller, the datapath and the top level.
// No dependencies.
package tcv_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAL_GAIN   = 3'd0,
		CFG_CAL_OFFSET = 3'd1,
		CFG_MAX_DUTY   = 3'd2,
		CFG_MIN_DUTY   = 3'd3,
		CFG_BOOST_DUTY = 3'd4,
		CFG_PWM_PERIOD = 3'd5
	} cfg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0]        RST_CAL_GAIN   = 16'd4096;
	localparam logic signed [12:0] RST_CAL_OFFSET = 13'sd0;
	localparam logic [11:0]        RST_MAX_DUTY   = 12'd3686;
	localparam logic [11:0]        RST_MIN_DUTY   = 12'd0;
	localparam logic [11:0]        RST_BOOST_DUTY = 12'd3809;
	localparam logic [15:0]        RST_PWM_PERIOD = 16'd30000;

	typedef struct packed {
		logic [15:0]        cal_gain;
		logic signed [12:0] cal_offset;
		logic [11:0]        max_duty;
		logic [11:0]        min_duty;
		logic [11:0]        boost_duty;
		logic [15:0]        pwm_period;
	} cfg_t;

	// filter coefficients, b on the error side (Q8), a on the output side (Q12)
	localparam logic signed [16:0] COEF_B0 = 17'sd4995;
	localparam logic signed [16:0] COEF_B1 = -17'sd4838;
	localparam logic signed [16:0] COEF_B2 = -17'sd4992;
	localparam logic signed [16:0] COEF_B3 = 17'sd4838;
	localparam logic signed [16:0] COEF_A1 = 17'sd5079;
	localparam logic signed [16:0] COEF_A2 = -17'sd1043;
	localparam logic signed [16:0] COEF_A3 = 17'sd60;

	// operand pair fed to the shared multiplier
	typedef enum logic [3:0] {
		MUL_CAL,
		MUL_U1,
		MUL_U2,
		MUL_U3,
		MUL_E0,
		MUL_E1,
		MUL_E2,
		MUL_E3,
		MUL_BUCK,
		MUL_BOOST
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic     load_in;
		mul_sel_t mul_sel;
		acc_op_t  acc_u_op;
		acc_op_t  acc_e_op;
		logic     calc_e0;
		logic     calc_u0;
		logic     calc_duty;
		logic     calc_buck;
		logic     load_out;
	} cmd_t;

endpackage

// File: rtl/core/tcv_cfg.sv
// Configuration register file of the compensator.
// Depends on tcv_pkg for register indexes, reset values and cfg_t.
module tcv_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [tcv_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [tcv_pkg::CFG_DATA_W-1:0]     wr_data,
	output tcv_pkg::cfg_t                      cfg
);

	tcv_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_gain   <= tcv_pkg::RST_CAL_GAIN;
			cfg_q.cal_offset <= tcv_pkg::RST_CAL_OFFSET;
			cfg_q.max_duty   <= tcv_pkg::RST_MAX_DUTY;
			cfg_q.min_duty   <= tcv_pkg::RST_MIN_DUTY;
			cfg_q.boost_duty <= tcv_pkg::RST_BOOST_DUTY;
			cfg_q.pwm_period <= tcv_pkg::RST_PWM_PERIOD;
		end else if (wr_en) begin
			case (wr_index)
				tcv_pkg::CFG_CAL_GAIN:   cfg_q.cal_gain   <= wr_data;
				tcv_pkg::CFG_CAL_OFFSET: cfg_q.cal_offset <= wr_data[12:0];
				tcv_pkg::CFG_MAX_DUTY:   cfg_q.max_duty   <= wr_data[11:0];
				tcv_pkg::CFG_MIN_DUTY:   cfg_q.min_duty   <= wr_data[11:0];
				tcv_pkg::CFG_BOOST_DUTY: cfg_q.boost_duty <= wr_data[11:0];
				tcv_pkg::CFG_PWM_PERIOD: cfg_q.pwm_period <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/tcv_ctrl.sv
// Sequencer of the compensator: steps the shared multiplier through one update.
// Depends on tcv_pkg for cmd_t and the operand and accumulator codes.
module tcv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output tcv_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAL,
		ST_E0,
		ST_U2,
		ST_U3,
		ST_E0B,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_SUM,
		ST_U0,
		ST_DUTY,
		ST_BUCK,
		ST_BOOST,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// a product issued in one state is accumulated in the next
	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = tcv_pkg::MUL_CAL;
		cmd.acc_u_op = tcv_pkg::ACC_HOLD;
		cmd.acc_e_op = tcv_pkg::ACC_HOLD;
		case (state_q)
			ST_IDLE:  cmd.load_in = in_valid;
			ST_CAL:   cmd.mul_sel = tcv_pkg::MUL_CAL;
			ST_E0: begin
				cmd.calc_e0 = 1'b1;
				cmd.mul_sel = tcv_pkg::MUL_U1;
			end
			ST_U2: begin
				cmd.mul_sel  = tcv_pkg::MUL_U2;
				cmd.acc_u_op = tcv_pkg::ACC_LOAD;
			end
			ST_U3: begin
				cmd.mul_sel  = tcv_pkg::MUL_U3;
				cmd.acc_u_op = tcv_pkg::ACC_ADD;
			end
			ST_E0B: begin
				cmd.mul_sel  = tcv_pkg::MUL_E0;
				cmd.acc_u_op = tcv_pkg::ACC_ADD;
			end
			ST_E1: begin
				cmd.mul_sel  = tcv_pkg::MUL_E1;
				cmd.acc_e_op = tcv_pkg::ACC_LOAD;
			end
			ST_E2: begin
				cmd.mul_sel  = tcv_pkg::MUL_E2;
				cmd.acc_e_op = tcv_pkg::ACC_ADD;
			end
			ST_E3: begin
				cmd.mul_sel  = tcv_pkg::MUL_E3;
				cmd.acc_e_op = tcv_pkg::ACC_ADD;
			end
			ST_SUM:   cmd.acc_e_op = tcv_pkg::ACC_ADD;
			ST_U0:    cmd.calc_u0 = 1'b1;
			ST_DUTY:  cmd.calc_duty = 1'b1;
			ST_BUCK:  cmd.mul_sel = tcv_pkg::MUL_BUCK;
			ST_BOOST: begin
				cmd.mul_sel   = tcv_pkg::MUL_BOOST;
				cmd.calc_buck = 1'b1;
			end
			// keep the boost product in place while the output is blocked
			ST_OUT: begin
				cmd.mul_sel  = tcv_pkg::MUL_BOOST;
				cmd.load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE:  if (in_valid) state_q <= ST_CAL;
				ST_CAL:   state_q <= ST_E0;
				ST_E0:    state_q <= ST_U2;
				ST_U2:    state_q <= ST_U3;
				ST_U3:    state_q <= ST_E0B;
				ST_E0B:   state_q <= ST_E1;
				ST_E1:    state_q <= ST_E2;
				ST_E2:    state_q <= ST_E3;
				ST_E3:    state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_U0;
				ST_U0:    state_q <= ST_DUTY;
				ST_DUTY:  state_q <= ST_BUCK;
				ST_BUCK:  state_q <= ST_BOOST;
				ST_BOOST: state_q <= ST_OUT;
				ST_OUT:   if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/tcv_dp.sv
// Datapath of the compensator: input capture, shared multiplier, accumulators,
// filter histories, duty clamp and output register. Depends on tcv_pkg.
module tcv_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  tcv_pkg::cmd_t cmd,
	input  tcv_pkg::cfg_t cfg,
	input  logic [11:0]   adc_sample,
	input  logic [14:0]   voltage_ref,
	input  logic          pwm_enable,
	output logic [15:0]   buck_compare,
	output logic [14:0]   adc_trigger_compare,
	output logic [15:0]   boost_compare,
	output logic [11:0]   duty_out
);

	logic [11:0]        adc_q;
	logic [14:0]        vref_q;
	logic               enable_q;

	logic signed [31:0] opa;
	logic signed [16:0] opb;
	logic signed [48:0] prod_q;

	logic signed [17:0] e0_q;
	logic signed [17:0] e_hist_q [3];
	logic signed [31:0] u_hist_q [3];
	logic signed [45:0] acc_u_q;
	logic signed [34:0] acc_e_q;
	logic signed [31:0] u0_q;
	logic [11:0]        duty_q;
	logic [15:0]        buck_q;

	logic signed [17:0] vcal;
	logic signed [35:0] u_sum;
	logic signed [31:0] u_sat;
	logic signed [31:0] max_s;
	logic signed [31:0] min_s;
	logic [11:0]        duty_next;
	logic [15:0]        prod_scaled;

	// history values enter the multiplier as signed 32-bit operands
	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.mul_sel)
			tcv_pkg::MUL_CAL: begin
				opa = {16'b0, cfg.cal_gain};
				opb = {5'b0, adc_q};
			end
			tcv_pkg::MUL_U1: begin
				opa = u_hist_q[0];
				opb = tcv_pkg::COEF_A1;
			end
			tcv_pkg::MUL_U2: begin
				opa = u_hist_q[1];
				opb = tcv_pkg::COEF_A2;
			end
			tcv_pkg::MUL_U3: begin
				opa = u_hist_q[2];
				opb = tcv_pkg::COEF_A3;
			end
			tcv_pkg::MUL_E0: begin
				opa = {{14{e0_q[17]}}, e0_q};
				opb = tcv_pkg::COEF_B0;
			end
			tcv_pkg::MUL_E1: begin
				opa = {{14{e_hist_q[0][17]}}, e_hist_q[0]};
				opb = tcv_pkg::COEF_B1;
			end
			tcv_pkg::MUL_E2: begin
				opa = {{14{e_hist_q[1][17]}}, e_hist_q[1]};
				opb = tcv_pkg::COEF_B2;
			end
			tcv_pkg::MUL_E3: begin
				opa = {{14{e_hist_q[2][17]}}, e_hist_q[2]};
				opb = tcv_pkg::COEF_B3;
			end
			tcv_pkg::MUL_BUCK: begin
				opa = {16'b0, cfg.pwm_period};
				opb = {5'b0, duty_q};
			end
			tcv_pkg::MUL_BOOST: begin
				opa = {16'b0, cfg.pwm_period};
				opb = {5'b0, cfg.boost_duty};
			end
			default: ;
		endcase
	end

	assign prod_scaled = prod_q[27:12];
	assign vcal = $signed({2'b0, prod_scaled})
		+ {{5{cfg.cal_offset[12]}}, cfg.cal_offset};

	// arithmetic shifts floor toward minus infinity, as the filter needs
	assign u_sum = {{2{acc_u_q[45]}}, acc_u_q[45:12]}
		+ {{9{acc_e_q[34]}}, acc_e_q[34:8]};

	always_comb begin
		if (u_sum[35:31] == 5'b00000 || u_sum[35:31] == 5'b11111)
			u_sat = u_sum[31:0];
		else if (u_sum[35])
			u_sat = 32'sh8000_0000;
		else
			u_sat = 32'sh7fff_ffff;
	end

	// upper clamp first, then a min override so that min wins when the limits cross
	assign max_s = $signed({20'b0, cfg.max_duty});
	assign min_s = $signed({20'b0, cfg.min_duty});
	always_comb begin
		duty_next = u0_q[11:0];
		if (u0_q > max_s)
			duty_next = cfg.max_duty;
		else if (u0_q < min_s)
			duty_next = cfg.min_duty;
		if (u0_q > max_s && max_s < min_s)
			duty_next = cfg.min_duty;
		if (!enable_q)
			duty_next = cfg.min_duty;
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
		if (cmd.load_in) begin
			adc_q    <= adc_sample;
			vref_q   <= voltage_ref;
			enable_q <= pwm_enable;
		end
		if (cmd.calc_e0)
			e0_q <= $signed({3'b0, vref_q}) - vcal;
		case (cmd.acc_u_op)
			tcv_pkg::ACC_LOAD: acc_u_q <= prod_q[45:0];
			tcv_pkg::ACC_ADD:  acc_u_q <= acc_u_q + prod_q[45:0];
			default: ;
		endcase
		case (cmd.acc_e_op)
			tcv_pkg::ACC_LOAD: acc_e_q <= prod_q[34:0];
			tcv_pkg::ACC_ADD:  acc_e_q <= acc_e_q + prod_q[34:0];
			default: ;
		endcase
		if (cmd.calc_u0)
			u0_q <= u_sat;
		if (cmd.calc_duty)
			duty_q <= duty_next;
		if (cmd.calc_buck)
			buck_q <= prod_scaled;
		if (cmd.load_out) begin
			buck_compare        <= buck_q;
			adc_trigger_compare <= buck_q[15:1];
			boost_compare       <= cfg.pwm_period - prod_scaled;
			duty_out            <= duty_q;
		end
	end

	// filter state is control state: it must start from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				e_hist_q[i] <= '0;
				u_hist_q[i] <= '0;
			end
		end else if (cmd.calc_u0) begin
			e_hist_q[2] <= e_hist_q[1];
			e_hist_q[1] <= e_hist_q[0];
			e_hist_q[0] <= e0_q;
			u_hist_q[2] <= u_hist_q[1];
			u_hist_q[1] <= u_hist_q[0];
			u_hist_q[0] <= u_sat;
		end
	end

endmodule

// File: rtl/core/type3_compensator_voltage_loop.sv
// Channel   Dir  Beat holds
// s_axis    in   tdata: adc_sample, voltage_ref; tuser: pwm_enable
// m_axis    out  tdata: buck_compare, adc_trigger_compare, boost_compare, duty_out
// cfg       in   cfg_index selects a register, cfg_data is written; always ready
//
// m_axis_tvalid rises as the sequencer leaves its last step; a new item is taken
// only once the last is done. One shared 32x17 multiplier is stepped through calibration,
// seven filter taps and the two compare products, one product per cycle, plus the
// sum, clamp and output load. The next item is accepted while a result waits on
// m_axis; the sequencer holds in its last step only if the previous result is still
// not taken. arst_n clears configuration to defaults and filter history to zero.
// Top level of the Type III voltage-loop compensator.
// Instantiates tcv_cfg, tcv_ctrl and tcv_dp; depends on tcv_pkg.
module type3_compensator_voltage_loop (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [31:0]                        s_axis_tdata,  // [11:0] adc_sample, [26:12] voltage_ref
	input  logic                               s_axis_tuser,  // [0] pwm_enable
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [15:0] buck_compare, [30:16] adc_trigger_compare, [46:31] boost_compare,
	// [58:47] duty_out
	output logic [63:0]                        m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tcv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tcv_pkg::CFG_DATA_W-1:0]     cfg_data
);

	tcv_pkg::cfg_t cfg;
	tcv_pkg::cmd_t cmd;
	logic [15:0]   buck_compare;
	logic [14:0]   adc_trigger_compare;
	logic [15:0]   boost_compare;
	logic [11:0]   duty_out;

	assign cfg_ready = 1'b1;

	tcv_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	tcv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	tcv_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.cfg                 (cfg),
		.adc_sample          (s_axis_tdata[11:0]),
		.voltage_ref         (s_axis_tdata[26:12]),
		.pwm_enable          (s_axis_tuser),
		.buck_compare        (buck_compare),
		.adc_trigger_compare (adc_trigger_compare),
		.boost_compare       (boost_compare),
		.duty_out            (duty_out)
	);

	assign m_axis_tdata = {5'b0, duty_out, boost_compare, adc_trigger_compare, buck_compare};

endmodule
